/* src/unique_index_fifo_unit_assert.svh */
// Assertion macros shared by the unique index queue.
`ifndef UNIQUE_INDEX_FIFO_UNIT_ASSERT_SVH
`define UNIQUE_INDEX_FIFO_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define UIF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define UIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/uif_pkg.sv */
package uif_pkg;

    // Field widths fixed by the stream format.
    localparam int unsigned IDX_W = 4;
    localparam int unsigned OCC_W = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned IDX_N = 16;

    // Opcode carried in the input tuser.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Control sequencer states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

/* src/unique_index_fifo_unit.sv */
// Queue of sensor indices in which each index appears at most once. Every request is an
// enqueue (tuser 0) or a dequeue (tuser 1) and yields exactly one result carrying a status,
// the dequeued index and the occupancy after the request. The indices sit in a ring memory
// with one-cycle synchronous read; one presence flag per index, held in flip-flops and
// cleared by reset, catches duplicates. An enqueue, and a dequeue from an empty queue,
// take one cycle; a successful dequeue takes two, because the oldest entry must be read
// from the ring memory before its result and flag update are known. A new request is taken
// while the previous result is being handed over, so the output register never blocks the
// input for longer than its consumer does.
module unique_index_fifo_unit #(
    parameter int unsigned SENSORS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [3:0] sensor_index, [7:4] zero
    input  logic        i_s_tuser,    // [0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // [3:0] dequeued_index, [8:4] occupancy, [15:9] zero
    output logic [1:0]  o_m_tuser     // [1:0] status
);

    localparam int unsigned PTR_W = $clog2(SENSORS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SENSORS - 1);

    // Ring memory of queued indices.
    logic [uif_pkg::IDX_W-1:0] r_ring [SENSORS];
    logic [uif_pkg::IDX_W-1:0] r_rd_data;

    // Control and payload registers.
    uif_pkg::t_state r_state, n_state;
    logic [uif_pkg::IDX_N-1:0] r_present, n_present;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [uif_pkg::OCC_W-1:0] r_count, n_count;
    logic r_out_valid, n_out_valid;
    uif_pkg::t_status r_status, n_status;
    logic [uif_pkg::IDX_W-1:0] r_deq, n_deq;
    logic [uif_pkg::OCC_W-1:0] r_occ, n_occ;

    logic w_accept;
    logic [uif_pkg::IDX_W-1:0] w_idx;
    logic w_wr_en;
    logic w_rd_en;

    assign w_idx = i_s_tdata[uif_pkg::IDX_W-1:0];
    assign o_s_tready = (r_state == uif_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept = i_s_tvalid && o_s_tready;

    // Next state, pointer, flag and result logic.
    always_comb begin
        n_state = r_state;
        n_present = r_present;
        n_head = r_head;
        n_tail = r_tail;
        n_count = r_count;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status = r_status;
        n_deq = r_deq;
        n_occ = r_occ;
        w_wr_en = 1'b0;
        w_rd_en = 1'b0;
        case (r_state)
            uif_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_deq = '0;
                    if (i_s_tuser == uif_pkg::OP_ENQ) begin
                        n_out_valid = 1'b1;
                        if (32'(w_idx) >= SENSORS || r_present[w_idx]) begin
                            n_status = uif_pkg::ST_DUP;
                        end else if (32'(r_count) >= SENSORS) begin
                            n_status = uif_pkg::ST_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_present[w_idx] = 1'b1;
                            n_tail = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                            n_status = uif_pkg::ST_OK;
                        end
                    end else if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_status = uif_pkg::ST_EMPTY;
                    end else begin
                        // Read the oldest entry into r_rd_data; the result is registered from it in S_READ.
                        w_rd_en = 1'b1;
                        n_head = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                        n_status = uif_pkg::ST_OK;
                        n_state = uif_pkg::S_READ;
                    end
                    n_occ = n_count;
                end
            end
            uif_pkg::S_READ: begin
                // Entries hold only indices below SENSORS, so the flag always exists.
                n_deq = r_rd_data;
                n_present[r_rd_data] = 1'b0;
                n_out_valid = 1'b1;
                n_state = uif_pkg::S_IDLE;
            end
            default: begin
                n_state = uif_pkg::S_IDLE;
            end
        endcase
    end

    // Ring memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring[r_tail] <= w_idx;
        end
        if (w_rd_en) begin
            r_rd_data <= r_ring[r_head];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uif_pkg::S_IDLE;
            r_present <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_present <= n_present;
            r_head <= n_head;
            r_tail <= n_tail;
            r_count <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_deq <= n_deq;
        r_occ <= n_occ;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser = r_status;
    assign o_m_tdata = {7'd0, r_occ, r_deq};

    `include "unique_index_fifo_unit_assert.svh"

    `UIF_ASSERT_SAME(a_flags_match_count, r_state == uif_pkg::S_IDLE, 32'($countones(r_present)) == 32'(r_count), "presence flags disagree with entry count")
    `UIF_ASSERT_SAME(a_read_slot_free, r_state == uif_pkg::S_READ, !r_out_valid, "output register busy while a dequeue read completes")
    `UIF_ASSERT_NEXT(a_deq_reads, w_accept && i_s_tuser == uif_pkg::OP_DEQ && r_count != '0, r_state == uif_pkg::S_READ && o_m_tvalid == 1'b0, "dequeue did not start a ring read")
    `UIF_ASSERT_SAME(a_count_bound, 1'b1, r_count <= uif_pkg::OCC_W'(uif_pkg::IDX_N), "entry count exceeds the number of indices")

endmodule
